// ----- rtl/u8d_pkg.sv -----
// Shared types and constants of the UTF-8 stream decoder.
`default_nettype none

package u8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CpReplacement = 21'h00FFFD;
  localparam logic [CpW-1:0] CpMaxScalar   = 21'h10FFFF;
  localparam logic [CpW-1:0] CpMin2        = 21'h000080;
  localparam logic [CpW-1:0] CpMin3        = 21'h000800;
  localparam logic [CpW-1:0] CpMin4        = 21'h010000;

  // Length of the open sequence; zero means none is open.
  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqTwo  = 3'd2;
  localparam logic [2:0] SeqThree = 3'd3;
  localparam logic [2:0] SeqFour = 3'd4;

  localparam logic [2:0] UsedOne = 3'd1;

  // Work handed from the front end to the back end for one input byte:
  // n_pre single-byte replacements, then optionally one final result.
  typedef struct packed {
    logic [1:0]     n_pre;
    logic           has_final;
    logic [CpW-1:0] code_point;
    logic           replaced;
    logic [2:0]     bytes_used;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/u8d_front.sv -----
// Front end: accepts bytes, tracks the open sequence and builds one job per byte.
`default_nettype none

module u8d_front
  import u8d_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       string_end_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [CpW-1:0] acc_q, acc_d;
  logic [2:0]     len_q, len_d;
  logic [1:0]     held_q, held_d;

  logic           accept;
  logic           is_cont;
  logic [2:0]     held_inc;
  logic [CpW-1:0] acc_ext;
  logic [CpW-1:0] min_val;
  logic           lead_go;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_cont    = (byte_value_i[7:6] == 2'b10);
  assign held_inc   = {1'b0, held_q} + 3'd1;
  assign acc_ext    = {acc_q[CpW-7:0], byte_value_i[5:0]};

  always_comb begin
    unique case (len_q)
      SeqTwo:   min_val = CpMin2;
      SeqThree: min_val = CpMin3;
      default:  min_val = CpMin4;
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    len_d   = len_q;
    held_d  = held_q;
    job_o   = '0;
    lead_go = 1'b0;

    if (len_q != SeqNone) begin
      if (is_cont) begin
        if (held_inc == len_q) begin
          job_o.has_final  = 1'b1;
          job_o.bytes_used = len_q;
          if ((acc_ext < min_val) || (acc_ext > CpMaxScalar)) begin
            job_o.code_point = CpReplacement;
            job_o.replaced   = 1'b1;
          end else begin
            job_o.code_point = acc_ext;
          end
          acc_d  = '0;
          len_d  = SeqNone;
          held_d = '0;
        end else if (string_end_i) begin
          job_o.n_pre = held_inc[1:0];
          acc_d  = '0;
          len_d  = SeqNone;
          held_d = '0;
        end else begin
          acc_d  = acc_ext;
          held_d = held_inc[1:0];
        end
      end else begin
        // Broken sequence: flush what is held, then decode this byte afresh.
        job_o.n_pre = held_q;
        acc_d   = '0;
        len_d   = SeqNone;
        held_d  = '0;
        lead_go = 1'b1;
      end
    end else begin
      lead_go = 1'b1;
    end

    if (lead_go) begin
      priority if (!byte_value_i[7]) begin
        job_o.has_final  = 1'b1;
        job_o.code_point = {13'd0, byte_value_i};
        job_o.bytes_used = UsedOne;
      end else if ((byte_value_i[7:5] == 3'b110) || (byte_value_i[7:4] == 4'b1110) ||
                   (byte_value_i[7:3] == 5'b11110)) begin
        if (string_end_i) begin
          job_o.has_final  = 1'b1;
          job_o.code_point = CpReplacement;
          job_o.replaced   = 1'b1;
          job_o.bytes_used = UsedOne;
        end else begin
          held_d = 2'd1;
          priority if (byte_value_i[7:5] == 3'b110) begin
            len_d = SeqTwo;
            acc_d = {16'd0, byte_value_i[4:0]};
          end else if (byte_value_i[7:4] == 4'b1110) begin
            len_d = SeqThree;
            acc_d = {17'd0, byte_value_i[3:0]};
          end else begin
            len_d = SeqFour;
            acc_d = {18'd0, byte_value_i[2:0]};
          end
        end
      end else begin
        job_o.has_final  = 1'b1;
        job_o.code_point = CpReplacement;
        job_o.replaced   = 1'b1;
        job_o.bytes_used = UsedOne;
      end
    end
  end

  assign push_o = accept && ((job_o.n_pre != 2'd0) || job_o.has_final);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      len_q  <= SeqNone;
      held_q <= '0;
    end else if (accept) begin
      acc_q  <= acc_d;
      len_q  <= len_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/u8d_queue.sv -----
// Two-entry job queue between the front end and the back end.
`default_nettype none

module u8d_queue
  import u8d_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  output logic      valid_o,
  output job_t      head_o,
  input  wire logic pop_i
);

  job_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/u8d_back.sv -----
// Back end: expands each job into result transactions through an output register.
`default_nettype none

module u8d_back
  import u8d_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   head_valid_i,
  input  wire job_t   head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [20:0] code_point_o,
  output logic        replaced_o,
  output logic [2:0]  bytes_used_o,
  output logic        run_last_o
);

  logic           out_valid_q;
  logic [CpW-1:0] cp_q;
  logic           rep_q;
  logic [2:0]     used_q;
  logic           last_q;
  logic [1:0]     idx_q, idx_d;

  logic           load;
  logic           in_pre;
  logic [CpW-1:0] cp_n;
  logic           rep_n;
  logic [2:0]     used_n;
  logic           last_n;

  assign load   = head_valid_i && (!out_valid_q || out_ready_i);
  assign in_pre = (idx_q < head_i.n_pre);

  always_comb begin
    if (in_pre) begin
      cp_n   = CpReplacement;
      rep_n  = 1'b1;
      used_n = UsedOne;
      last_n = ((idx_q + 2'd1) == head_i.n_pre) && !head_i.has_final;
    end else begin
      cp_n   = head_i.code_point;
      rep_n  = head_i.replaced;
      used_n = head_i.bytes_used;
      last_n = 1'b1;
    end
    idx_d = last_n ? 2'd0 : idx_q + 2'd1;
  end

  assign pop_o = load && last_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= cp_n;
      rep_q  <= rep_n;
      used_q <= used_n;
      last_q <= last_n;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign replaced_o   = rep_q;
  assign bytes_used_o = used_q;
  assign run_last_o   = last_q;

endmodule

`default_nettype wire

// ----- rtl/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder with replacement character.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         in_valid_i / in_ready_o    byte_value_i, string_end_i
//   output   out        out_valid_o / out_ready_i  code_point_o, replaced_o,
//                                                  bytes_used_o, run_last_o
//
// One byte can be accepted in every cycle while the job queue is not full; a byte
// that yields n results (n is 0 to 4) holds the back end until all are emitted,
// since the output register emits one result transaction per cycle while
// out_ready_i is high. The first result of a byte passes through the job queue
// and then the output register before it is presented. A two-entry job
// queue separates the front end from the back end, so input is refused only once
// both entries are full. Reset closes any open sequence and empties the queue and
// the output register.
`default_nettype none

module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        string_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [20:0]      code_point_o,
  output logic             replaced_o,
  output logic [2:0]       bytes_used_o,
  output logic             run_last_o
);

  // Front end to queue: one job for every byte that produces any result.
  logic push;
  job_t job;
  logic q_full;

  // Queue to back end.
  logic q_valid;
  job_t q_head;
  logic pop;

  // The front end classifies each byte, updates the partial sequence and decides
  // how many replacement characters precede the final result, if any.
  u8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .string_end_i (string_end_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (job)
  );

  u8d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (pop)
  );

  // The back end walks through each job, one result transaction per cycle unless
  // stalled, and marks the last so the consumer can tell where a byte's run ends.
  u8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .replaced_o   (replaced_o),
    .bytes_used_o (bytes_used_o),
    .run_last_o   (run_last_o)
  );

  // A replacement is always U+FFFD.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && replaced_o |-> code_point_o == CpReplacement)
    else $error("replacement result carries a value other than U+FFFD");

  // A result that consumed several bytes is a completed sequence and closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bytes_used_o != UsedOne) |-> run_last_o)
    else $error("multi-byte result is not the last of its run");

  // A good single-byte result is plain ASCII.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !replaced_o && (bytes_used_o == UsedOne) |-> code_point_o < 21'd128)
    else $error("single-byte result outside the ASCII range");

  // A job leaves the queue only when the back end loads its last result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && run_last_o)
    else $error("job retired without a final result in the output register");

endmodule

`default_nettype wire
